@@ rtl/rrts_pkg.sv @@
// Shared types and constants of the round-robin task scheduler.
// Used by rrts_elig, rrts_table and round_robin_task_scheduler; depends on nothing.
package rrts_pkg;

  localparam int unsigned TID_W  = 7;
  localparam int unsigned DUR_W  = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned KEY_W  = 9;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_EXIT     = 3'd1,
    OP_WAIT     = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_READ_KEY = 3'd4,
    OP_POLL     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_RUNNABLE = 3'd0,
    ST_WAITING  = 3'd1,
    ST_SLEEPING = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_DONE     = 3'd4
  } task_st_e;

  typedef enum logic [STAT_W-1:0] {
    RES_OK   = 2'd0,
    RES_FULL = 2'd1,
    RES_IDLE = 2'd2
  } res_status_e;

  typedef struct packed {
    res_status_e       status;
    logic [TID_W-1:0]  next_task;
    logic              switched;
    logic [TID_W-1:0]  new_handle;
    logic              key_delivered;
    logic [KEY_W-1:0]  delivered_key;
  } res_t;

  // One write port shared by the three task tables; the address travels apart.
  typedef struct packed {
    logic              st_we;
    task_st_e          st_data;
    logic              wk_we;
    logic [TIME_W-1:0] wk_data;
    logic              aw_we;
    logic [TID_W-1:0]  aw_data;
  } tbl_wr_t;

  typedef struct packed {
    logic pick;
    logic took_key;
    logic need_tgt;
  } elig_t;

endpackage

@@ rtl/rrts_elig.sv @@
// Eligibility unit: decides from one slot's status whether the scan picks it.
// Holds the wake-time comparator shared by every scan step; uses rrts_pkg.
module rrts_elig (
  input  rrts_pkg::task_st_e              st_i,
  input  logic [rrts_pkg::TIME_W-1:0]     wake_i,
  input  logic [rrts_pkg::TIME_W-1:0]     now_i,
  input  logic                            key_valid_i,
  output rrts_pkg::elig_t                 elig_o
);

  logic woke;

  assign woke = (wake_i < now_i);

  always_comb begin
    elig_o = '0;
    case (st_i)
      rrts_pkg::ST_RUNNABLE: elig_o.pick = 1'b1;
      // the target's status comes from a second table read
      rrts_pkg::ST_WAITING:  elig_o.need_tgt = 1'b1;
      rrts_pkg::ST_SLEEPING: elig_o.pick = woke;
      rrts_pkg::ST_BLOCKED: begin
        elig_o.pick     = key_valid_i;
        elig_o.took_key = key_valid_i;
      end
      default: elig_o = '0;
    endcase
  end

endmodule

@@ rtl/rrts_table.sv @@
// Task tables: status, wake time and awaited task per slot, one write and one
// registered read per cycle. Slots at or above the fill count, and slot 0 until
// its first status write, read as runnable; uses rrts_pkg.
module rrts_table #(
  parameter  int unsigned TASK_SLOTS = 128,
  localparam int unsigned IDX_W      = $clog2(TASK_SLOTS),
  localparam int unsigned CW         = $clog2(TASK_SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [IDX_W-1:0]              waddr_i,
  input  rrts_pkg::tbl_wr_t             wr_i,
  input  logic [IDX_W-1:0]              raddr_i,
  input  logic [CW-1:0]                 fill_i,
  output rrts_pkg::task_st_e            st_o,
  output logic [rrts_pkg::TIME_W-1:0]   wake_o,
  output logic [rrts_pkg::TID_W-1:0]    awaited_o
);

  rrts_pkg::task_st_e              st_mem [TASK_SLOTS];
  logic [rrts_pkg::TIME_W-1:0]     wk_mem [TASK_SLOTS];
  logic [rrts_pkg::TID_W-1:0]      aw_mem [TASK_SLOTS];

  rrts_pkg::task_st_e              st_rd_q;
  logic                            inr_q;
  logic                            slot0_wr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.st_we) st_mem[waddr_i] <= wr_i.st_data;
    if (wr_i.wk_we) wk_mem[waddr_i] <= wr_i.wk_data;
    if (wr_i.aw_we) aw_mem[waddr_i] <= wr_i.aw_data;
    st_rd_q   <= st_mem[raddr_i];
    wake_o    <= wk_mem[raddr_i];
    awaited_o <= aw_mem[raddr_i];
    inr_q     <= (CW'(raddr_i) < fill_i) && ((raddr_i != '0) || slot0_wr_q);
  end

  // slot 0 exists from reset but is never created, so track its first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_wr_q <= 1'b0;
    end else if (wr_i.st_we && (waddr_i == '0)) begin
      slot0_wr_q <= 1'b1;
    end
  end

  // never written slots still hold their reset status
  assign st_o = inr_q ? st_rd_q : rrts_pkg::ST_RUNNABLE;

endmodule

@@ rtl/round_robin_task_scheduler.sv @@
// Round-robin task scheduler: event sequencer, task tables and eligibility unit.
// Depends on rrts_pkg, rrts_table and rrts_elig.
//
// One beat on the slave side is one scheduling event; tuser carries the op,
// tdata the target task, sleep length, current time and offered key. Each event
// gives exactly one beat on the master side: status in tuser, the task that runs
// next, the switch flag, a created handle and a delivered key in tdata.
// Create, an unused op and a read key with a key at hand go from accept through
// dispatch straight to the result. Every other event scans the created slots
// round-robin, starting after the running task; each slot visited takes a read
// and an evaluation step through the single table read port, and a waiting slot
// with its target in the table adds a check of its target's status. One event is
// in work at a time: s_axis_tready is high only while the sequencer waits for an event.
// The result sits in an output register, so the next event is taken while it
// waits; a stalled receiver holds that beat and the finished event after it
// waits for the register to free. Reset makes every slot runnable, task 0
// running and the task count one at once: the status table is tracked by the
// fill count and a written flag for slot 0, so there is no clearing pass.
module round_robin_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // target_task[6:0], duration_ms[38:7], now_ms[86:39], key_valid[87],
  // key_code[96:88], zero fill up to bit 103
  input  logic [rrts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // op[2:0]
  input  logic [rrts_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // next_task[6:0], switched[7], new_handle[14:8], key_delivered[15],
  // delivered_key[24:16], zero fill up to bit 31
  output logic [rrts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [rrts_pkg::STAT_W-1:0]          m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam int unsigned CW    = $clog2(TASK_SLOTS + 1);
  localparam int unsigned TW    = (CW > rrts_pkg::TID_W) ? CW : rrts_pkg::TID_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_EVAL,
    S_TCHK,
    S_RESP
  } state_e;

  state_e                          state_q;
  state_e                          state_d;
  logic [rrts_pkg::OP_W-1:0]       op_q;
  logic [rrts_pkg::TID_W-1:0]      tgt_q;
  logic [rrts_pkg::DUR_W-1:0]      dur_q;
  logic [rrts_pkg::TIME_W-1:0]     now_q;
  logic                            kv_q;
  logic [rrts_pkg::KEY_W-1:0]      key_q;
  logic [IDX_W-1:0]                running_q;
  logic [IDX_W-1:0]                running_d;
  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   count_d;
  logic [IDX_W-1:0]                idx_q;
  logic [IDX_W-1:0]                idx_d;
  logic [CW-1:0]                   n_q;
  logic [CW-1:0]                   n_d;
  rrts_pkg::res_t                  res_q;
  rrts_pkg::res_t                  res_d;
  rrts_pkg::res_t                  m_res_q;
  logic                            m_valid_q;
  logic                            m_valid_d;

  rrts_pkg::tbl_wr_t               wr;
  logic [IDX_W-1:0]                waddr;
  logic [IDX_W-1:0]                raddr;
  rrts_pkg::task_st_e              rd_st;
  logic [rrts_pkg::TIME_W-1:0]     rd_wake;
  logic [rrts_pkg::TID_W-1:0]      rd_aw;
  rrts_pkg::elig_t                 elig;

  logic [TW-1:0]                   tgt_w;
  logic                            tgt_in_tbl;
  logic [IDX_W-1:0]                tgt_idx;
  logic [CW-1:0]                   cur_inc;
  logic [IDX_W-1:0]                cur_next;
  logic [CW-1:0]                   idx_inc;
  logic [IDX_W-1:0]                idx_next;
  logic                            table_full;
  logic                            tpick;
  logic                            took;
  logic                            scan_last;
  logic                            out_free;

  rrts_table #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .waddr_i   (waddr),
    .wr_i      (wr),
    .raddr_i   (raddr),
    .fill_i    (count_q),
    .st_o      (rd_st),
    .wake_o    (rd_wake),
    .awaited_o (rd_aw)
  );

  rrts_elig u_elig (
    .st_i        (rd_st),
    .wake_i      (rd_wake),
    .now_i       (now_q),
    .key_valid_i (kv_q),
    .elig_o      (elig)
  );

  assign tgt_w      = TW'(rd_aw);
  assign tgt_in_tbl = (tgt_w < TW'(TASK_SLOTS));
  assign tgt_idx    = tgt_w[IDX_W-1:0];

  assign cur_inc  = CW'(running_q) + CW'(1);
  assign cur_next = (cur_inc >= count_q) ? '0 : cur_inc[IDX_W-1:0];
  assign idx_inc  = CW'(idx_q) + CW'(1);
  assign idx_next = (idx_inc >= count_q) ? '0 : idx_inc[IDX_W-1:0];

  assign table_full = (count_q >= CW'(TASK_SLOTS));
  assign tpick      = (rd_st == rrts_pkg::ST_DONE);
  assign took       = (state_q == S_EVAL) && elig.took_key;
  assign scan_last  = ((n_q + CW'(1)) == count_q);
  assign out_free   = !m_valid_q || m_axis_tready;

  // second read of a waiting slot goes to its target
  assign raddr = (state_q == S_EVAL) ? tgt_idx : idx_q;

  always_comb begin
    wr         = '0;
    wr.st_data = rrts_pkg::ST_RUNNABLE;
    wr.wk_data = now_q + rrts_pkg::TIME_W'(dur_q);
    wr.aw_data = tgt_q;
    waddr      = running_q;
    case (state_q)
      S_DISPATCH: begin
        case (op_q)
          rrts_pkg::OP_CREATE: begin
            wr.st_we = !table_full;
            waddr    = count_q[IDX_W-1:0];
          end
          rrts_pkg::OP_EXIT: begin
            wr.st_we   = 1'b1;
            wr.st_data = rrts_pkg::ST_DONE;
          end
          rrts_pkg::OP_WAIT: begin
            wr.st_we   = 1'b1;
            wr.st_data = rrts_pkg::ST_WAITING;
            wr.aw_we   = 1'b1;
          end
          rrts_pkg::OP_SLEEP: begin
            wr.st_we   = 1'b1;
            wr.st_data = rrts_pkg::ST_SLEEPING;
            wr.wk_we   = 1'b1;
          end
          rrts_pkg::OP_READ_KEY: begin
            wr.st_we   = 1'b1;
            wr.st_data = kv_q ? rrts_pkg::ST_RUNNABLE : rrts_pkg::ST_BLOCKED;
          end
          default: wr.st_we = 1'b0;
        endcase
      end
      S_EVAL: begin
        wr.st_we = elig.pick;
        waddr    = idx_q;
      end
      S_TCHK: begin
        wr.st_we = tpick;
        waddr    = idx_q;
      end
      default: wr.st_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    count_d   = count_q;
    idx_d     = idx_q;
    n_d       = n_q;
    res_d     = res_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_d           = '0;
        res_d.status    = rrts_pkg::RES_OK;
        res_d.next_task = rrts_pkg::TID_W'(running_q);
        idx_d           = cur_next;
        n_d             = '0;
        state_d         = S_READ;
        case (op_q)
          rrts_pkg::OP_CREATE: begin
            state_d = S_RESP;
            if (table_full) begin
              res_d.status = rrts_pkg::RES_FULL;
            end else begin
              res_d.new_handle = rrts_pkg::TID_W'(count_q);
              count_d          = count_q + CW'(1);
            end
          end
          rrts_pkg::OP_EXIT, rrts_pkg::OP_WAIT, rrts_pkg::OP_SLEEP,
          rrts_pkg::OP_POLL: state_d = S_READ;
          rrts_pkg::OP_READ_KEY: begin
            // a key at hand goes straight to the running task
            if (kv_q) begin
              res_d.key_delivered = 1'b1;
              res_d.delivered_key = key_q;
              state_d             = S_RESP;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_READ: state_d = S_EVAL;
      S_EVAL, S_TCHK: begin
        if ((state_q == S_EVAL && elig.pick) || (state_q == S_TCHK && tpick)) begin
          running_d           = idx_q;
          res_d.status        = rrts_pkg::RES_OK;
          res_d.next_task     = rrts_pkg::TID_W'(idx_q);
          res_d.switched      = (idx_q != running_q);
          res_d.key_delivered = took;
          res_d.delivered_key = took ? key_q : '0;
          state_d             = S_RESP;
        end else if (state_q == S_EVAL && elig.need_tgt && tgt_in_tbl) begin
          state_d = S_TCHK;
        end else if (scan_last) begin
          res_d.status = rrts_pkg::RES_IDLE;
          state_d      = S_RESP;
        end else begin
          n_d     = n_q + CW'(1);
          idx_d   = idx_next;
          state_d = S_READ;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= '0;
      count_q   <= CW'(1);
      m_valid_q <= 1'b0;
      n_q       <= '0;
      idx_q     <= '0;
      res_q     <= '0;
      m_res_q   <= '0;
      op_q      <= '0;
      tgt_q     <= '0;
      dur_q     <= '0;
      now_q     <= '0;
      kv_q      <= 1'b0;
      key_q     <= '0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      n_q       <= n_d;
      idx_q     <= idx_d;
      res_q     <= res_d;
      if (state_q == S_IDLE && s_axis_tvalid) begin
        op_q  <= s_axis_tuser;
        tgt_q <= s_axis_tdata[6:0];
        dur_q <= s_axis_tdata[38:7];
        now_q <= s_axis_tdata[86:39];
        kv_q  <= s_axis_tdata[87];
        key_q <= s_axis_tdata[96:88];
      end
      if (state_q == S_RESP && out_free) m_res_q <= res_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {7'b0, m_res_q.delivered_key, m_res_q.key_delivered,
                          m_res_q.new_handle, m_res_q.switched, m_res_q.next_task};

  a_running_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(running_q) < count_q)
    else $error("running task outside the created slots");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CW'(TASK_SLOTS)))
    else $error("task count out of range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_EVAL || state_q == S_TCHK) |-> (n_q < count_q))
    else $error("scan ran past the created slots");

  a_idle_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == rrts_pkg::STAT_W'(rrts_pkg::RES_IDLE))
      |-> (!m_axis_tdata[7] && !m_axis_tdata[15]))
    else $error("idle result reports a switch or a key");

endmodule

@@ tb/round_robin_task_scheduler_tb.sv @@
// Self-checking testbench for round_robin_task_scheduler: directed events, then
// random event streams, all checked against a task-table predictor in a scoreboard.
// Depends on rrts_pkg and the round_robin_task_scheduler RTL.
`timescale 1ns / 1ps

module round_robin_task_scheduler_tb;

  localparam int unsigned TASK_SLOTS   = 128;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RANDOM_BEATS = 1300;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned DRAIN_CYCLES = 3 * TASK_SLOTS + 20;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [rrts_pkg::OP_W-1:0]   OP_SPARE_LO = 3'd6;
  localparam logic [rrts_pkg::OP_W-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic [rrts_pkg::TIME_W-1:0] TIME_MAX    = '1;

  // Task table mirror plus the queue of results still owed by the block.
  class sched_scoreboard;
    rrts_pkg::task_st_e          slot_st[TASK_SLOTS];
    logic [rrts_pkg::TIME_W-1:0] wake_at[TASK_SLOTS];
    logic [rrts_pkg::TID_W-1:0]  waits_on[TASK_SLOTS];
    int unsigned                 running;
    int unsigned                 created;
    rrts_pkg::res_t              owed_q[$];
    int unsigned                 fail_count;
    int unsigned                 beats_seen;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i]  = rrts_pkg::ST_RUNNABLE;
        wake_at[i]  = '0;
        waits_on[i] = '0;
      end
      running    = 0;
      created    = 1;
      fail_count = 0;
      beats_seen = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH beat %0d: %s", beats_seen, msg);
      fail_count++;
    endtask

    function int unsigned live_tasks();
      int unsigned cnt;
      cnt = 0;
      for (int i = 0; i < created; i++)
        if (slot_st[i] != rrts_pkg::ST_DONE) cnt++;
      return cnt;
    endfunction

    // Prefer a finished task so that waiters make progress.
    function logic [rrts_pkg::TID_W-1:0] done_target();
      int unsigned finished[$];
      for (int i = 0; i < created; i++)
        if (slot_st[i] == rrts_pkg::ST_DONE) finished.push_back(i);
      if (finished.size() == 0)
        return rrts_pkg::TID_W'($urandom_range(created - 1));
      return rrts_pkg::TID_W'(finished[$urandom_range(finished.size() - 1)]);
    endfunction

    function void note_event(logic [rrts_pkg::OP_W-1:0] op,
                             logic [rrts_pkg::TID_W-1:0] tgt,
                             logic [rrts_pkg::DUR_W-1:0] dur,
                             logic [rrts_pkg::TIME_W-1:0] now,
                             bit kv, logic [rrts_pkg::KEY_W-1:0] kc);
      rrts_pkg::res_t r;
      int unsigned    cur;
      int unsigned    idx;
      bit             scan;
      bit             pick;
      bit             took;
      r           = '0;
      r.status    = rrts_pkg::RES_OK;
      cur         = running;
      r.next_task = rrts_pkg::TID_W'(cur);
      scan        = 1'b1;
      case (op)
        rrts_pkg::OP_CREATE: begin
          scan = 1'b0;
          if (created >= TASK_SLOTS) begin
            r.status = rrts_pkg::RES_FULL;
          end else begin
            slot_st[created] = rrts_pkg::ST_RUNNABLE;
            r.new_handle     = rrts_pkg::TID_W'(created);
            created++;
          end
        end
        rrts_pkg::OP_EXIT: slot_st[cur] = rrts_pkg::ST_DONE;
        rrts_pkg::OP_WAIT: begin
          slot_st[cur]  = rrts_pkg::ST_WAITING;
          waits_on[cur] = tgt;
        end
        rrts_pkg::OP_SLEEP: begin
          wake_at[cur] = now + dur;  // wraps at the time width
          slot_st[cur] = rrts_pkg::ST_SLEEPING;
        end
        rrts_pkg::OP_READ_KEY: begin
          if (kv) begin
            // key at hand: the running task keeps the processor
            scan            = 1'b0;
            slot_st[cur]    = rrts_pkg::ST_RUNNABLE;
            r.key_delivered = 1'b1;
            r.delivered_key = kc;
          end else begin
            slot_st[cur] = rrts_pkg::ST_BLOCKED;
          end
        end
        rrts_pkg::OP_POLL: ;
        default: scan = 1'b0;
      endcase
      if (scan) begin
        r.status = rrts_pkg::RES_IDLE;
        idx      = cur;
        for (int n = 0; n < created && r.status == rrts_pkg::RES_IDLE; n++) begin
          idx = (idx + 1 >= created) ? 0 : idx + 1;
          case (slot_st[idx])
            rrts_pkg::ST_RUNNABLE: pick = 1'b1;
            rrts_pkg::ST_WAITING:  pick = (slot_st[waits_on[idx]] == rrts_pkg::ST_DONE);
            rrts_pkg::ST_SLEEPING: pick = (wake_at[idx] < now);
            rrts_pkg::ST_BLOCKED:  pick = kv;
            default:               pick = 1'b0;
          endcase
          if (pick) begin
            took            = (slot_st[idx] == rrts_pkg::ST_BLOCKED);
            slot_st[idx]    = rrts_pkg::ST_RUNNABLE;
            running         = idx;
            r.status        = rrts_pkg::RES_OK;
            r.next_task     = rrts_pkg::TID_W'(idx);
            r.switched      = (idx != cur);
            r.key_delivered = took;
            r.delivered_key = took ? kc : '0;
          end
        end
      end
      owed_q.push_back(r);
    endfunction

    task check_result(logic [rrts_pkg::OUT_TDATA_W-1:0] data,
                      logic [rrts_pkg::STAT_W-1:0] stat);
      rrts_pkg::res_t want;
      beats_seen++;
      if (owed_q.size() == 0) begin
        flag_mismatch("result beat with no event outstanding");
        return;
      end
      want = owed_q.pop_front();
      if (stat !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", stat, want.status));
      if (data[6:0] !== want.next_task)
        flag_mismatch($sformatf("next_task %0d, want %0d", data[6:0], want.next_task));
      if (data[7] !== want.switched)
        flag_mismatch($sformatf("switched %0b, want %0b", data[7], want.switched));
      if (data[14:8] !== want.new_handle)
        flag_mismatch($sformatf("new_handle %0d, want %0d", data[14:8], want.new_handle));
      if (data[15] !== want.key_delivered)
        flag_mismatch($sformatf("key_delivered %0b, want %0b", data[15],
                                want.key_delivered));
      if (data[24:16] !== want.delivered_key)
        flag_mismatch($sformatf("delivered_key %0h, want %0h", data[24:16],
                                want.delivered_key));
    endtask
  endclass

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rrts_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [rrts_pkg::OP_W-1:0]        s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rrts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [rrts_pkg::STAT_W-1:0]      m_axis_tuser;

  sched_scoreboard             sb = new();
  int unsigned                 src_idle_pct = 0;
  int unsigned                 snk_stall_pct = 0;
  bit                          hold_req = 1'b0;
  int unsigned                 hold_left = 0;
  logic [rrts_pkg::TIME_W-1:0] sim_now = '0;

  round_robin_task_scheduler #(.TASK_SLOTS(TASK_SLOTS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Offer one event beat; entered and left at a falling edge.
  task automatic send_event(logic [rrts_pkg::OP_W-1:0] op,
                            logic [rrts_pkg::TID_W-1:0] tgt,
                            logic [rrts_pkg::DUR_W-1:0] dur,
                            logic [rrts_pkg::TIME_W-1:0] now,
                            bit kv, logic [rrts_pkg::KEY_W-1:0] kc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= rrts_pkg::IN_TDATA_W'({kc, kv, now, dur, tgt});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_event(op, tgt, dur, now, kv, kc);
    @(negedge clk_i);
  endtask

  task automatic random_event(bit fill_table);
    logic [rrts_pkg::OP_W-1:0]   op;
    logic [rrts_pkg::TID_W-1:0]  tgt;
    logic [rrts_pkg::DUR_W-1:0]  dur;
    logic [rrts_pkg::TIME_W-1:0] now;
    int unsigned                 roll;
    int unsigned                 live;
    live = sb.live_tasks();
    roll = $urandom_range(99);
    if (fill_table ? roll < 40 : (live < 4 ? roll < 30 : roll < 4)) begin
      op = rrts_pkg::OP_CREATE;
    end else begin
      roll = $urandom_range(99);
      if (roll < 6)       op = (live > 2) ? rrts_pkg::OP_EXIT : rrts_pkg::OP_POLL;
      else if (roll < 22) op = rrts_pkg::OP_WAIT;
      else if (roll < 42) op = rrts_pkg::OP_SLEEP;
      else if (roll < 64) op = rrts_pkg::OP_READ_KEY;
      else if (roll < 97) op = rrts_pkg::OP_POLL;
      else if (roll < 99) op = OP_SPARE_LO;
      else                op = OP_SPARE_HI;
    end
    tgt = ($urandom_range(99) < 70) ? sb.done_target()
                                    : rrts_pkg::TID_W'($urandom_range(127));
    dur = ($urandom_range(99) < 85) ? rrts_pkg::DUR_W'($urandom_range(40))
                                    : rrts_pkg::DUR_W'($urandom());
    roll = $urandom_range(99);
    if (roll < 3) begin
      sim_now = rrts_pkg::TIME_W'({$urandom(), $urandom()});
      now     = sim_now;
    end else if (roll < 6) begin
      // stray timestamp, the running clock stays put
      now = rrts_pkg::TIME_W'({$urandom(), $urandom()});
    end else begin
      sim_now = sim_now + $urandom_range(15);
      now     = sim_now;
    end
    send_event(op, tgt, dur, now, $urandom_range(1),
               rrts_pkg::KEY_W'($urandom_range(511)));
  endtask

  initial begin
    int unsigned src_plan[PHASES];
    int unsigned snk_plan[PHASES];
    src_plan = '{0, 81, 0, 23, 0};
    snk_plan = '{0, 0, 81, 23, 0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: single task, keys, spare codes, then waits, sleeps and exits
    send_event(rrts_pkg::OP_POLL, 0, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_READ_KEY, 0, 0, 0, 1'b1, 9'h1FF);
    send_event(rrts_pkg::OP_READ_KEY, 0, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_POLL, 0, 0, 0, 1'b1, 0);
    send_event(OP_SPARE_LO, '1, '1, TIME_MAX, 1'b1, '1);
    send_event(OP_SPARE_HI, '1, '1, TIME_MAX, 1'b1, '1);
    repeat (3) send_event(rrts_pkg::OP_CREATE, 0, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_WAIT, 2, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_SLEEP, 0, '1, TIME_MAX, 1'b0, 0);
    send_event(rrts_pkg::OP_EXIT, 0, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_WAIT, 127, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_SLEEP, 0, 0, 0, 1'b0, 0);
    send_event(rrts_pkg::OP_POLL, 0, 0, 1, 1'b0, 0);
    send_event(rrts_pkg::OP_POLL, 0, 0, 48'h1_0000_0000, 1'b0, 0);
    send_event(rrts_pkg::OP_READ_KEY, 0, 0, 48'h1_0000_0000, 1'b0, 0);
    send_event(rrts_pkg::OP_POLL, 0, 0, 48'h1_0000_0001, 1'b1, 9'h0AA);
    send_event(rrts_pkg::OP_CREATE, 0, 0, 48'h1_0000_0001, 1'b0, 0);
    sim_now = 48'h1_0000_0010;

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct  = src_plan[p];
      snk_stall_pct = snk_plan[p];
      // last phase: stall the output long enough to back up the input
      if (p == PHASES - 1) hold_req = 1'b1;
      repeat (RANDOM_BEATS / PHASES) random_event(p == PHASES - 1);
    end
    s_axis_tvalid <= 1'b0;
    snk_stall_pct = 0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0)
      $display("round_robin_task_scheduler verification clean");
    else
      $display("round_robin_task_scheduler verification failed");
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("round_robin_task_scheduler verification failed");
    $finish;
  end

endmodule
